[rtl/core/zero_one_range_encoder_assert.svh]
// Assertion macros for the zero/one range encoder checker.
// Depends on signals clk and rst_n in the scope that uses the macros.
`ifndef ZERO_ONE_RANGE_ENCODER_ASSERT_SVH
`define ZERO_ONE_RANGE_ENCODER_ASSERT_SVH

// The consequence must hold in the cycle after the antecedent.
`define ZOR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequence must hold in the same cycle as the antecedent.
`define ZOR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/zor_pkg.sv]
// Shared types and constants of the zero/one range encoder.
// No dependencies; used by every module of the block.
package zor_pkg;

  localparam int VALUE_BITS  = 31;
  localparam int MAX_RESULTS = 32;
  localparam int POS_W       = 6;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int MODE_W      = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_ZERO = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_ONE  = MODE_W'(1);

  typedef enum logic [1:0] {
    OP_ZERO,
    OP_ONE,
    OP_CMP
  } op_t;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [VALUE_BITS-1:0] value_a;
    logic [VALUE_BITS-1:0] value_b;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] element;
    logic                  is_last;
    logic                  is_empty;
    logic                  matched;
    logic [POS_W-1:0]      zero_position;
    logic [POS_W-1:0]      one_position;
  } out_item_t;

  typedef struct packed {
    op_t                   op;
    logic [VALUE_BITS-1:0] val_a;
    logic [VALUE_BITS-1:0] val_b;
    logic                  is_empty;
  } job_t;

endpackage

[rtl/core/zero_one_range_encoder.sv]
// Zero/one range encoder top level: front classifier, job queue, back walker.
// Depends on zor_pkg, zor_front and zor_back.
//
// Items enter through a two-deep job queue, and results leave through a
// one-beat output register that refills in the cycle it is popped. Encode
// items (mode 0 and 1) give their set elements smallest first, at most one
// per cycle, with is_last on the final one; an empty set gives one beat with
// is_empty set. Compare items give exactly one beat. The back end walks
// each value one bit per cycle, stalling only while a result waits for
// the output register: after taking the item it shifts out the leading
// zeros in S_NORM, then steps through the remaining bits in S_WALK. A
// compare item ends when the two values differ in a bit or when the
// shorter value has run out.
module zero_one_range_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  zor_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output zor_pkg::out_item_t out_data
);

  logic          job_valid;
  logic          job_take;
  zor_pkg::job_t job;

  zor_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  zor_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

[rtl/core/zor_front.sv]
// Front end of the zero/one range encoder: classifies input beats into jobs.
// Holds the short job queue toward the back end. Depends on zor_pkg.
module zor_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  zor_pkg::in_item_t in_data,
  output logic             job_valid,
  output zor_pkg::job_t    job,
  input  logic             job_take
);

  localparam int W     = zor_pkg::VALUE_BITS;
  localparam int QD    = zor_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(QD);
  localparam int QC_W  = $clog2(QD + 1);

  logic [W-1:0]       a_inc;
  logic [W-1:0]       b_inc;
  logic               zero_none;
  zor_pkg::job_t      job_in;
  zor_pkg::job_t      q_r [QD];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]    cnt_r, cnt_nxt;
  logic               push_ok;
  logic               take_ok;

  assign a_inc     = in_data.value_a + W'(1);
  assign b_inc     = in_data.value_b + W'(1);
  assign zero_none = ~|(in_data.value_a & a_inc);

  always_comb begin
    job_in.val_a = in_data.value_a;
    job_in.val_b = b_inc;
    case (in_data.mode)
      zor_pkg::MODE_ZERO: begin
        job_in.op       = zor_pkg::OP_ZERO;
        job_in.is_empty = zero_none;
      end
      zor_pkg::MODE_ONE: begin
        job_in.op       = zor_pkg::OP_ONE;
        job_in.val_a    = a_inc;
        job_in.is_empty = ~|a_inc;
      end
      default: begin
        job_in.op       = zor_pkg::OP_CMP;
        job_in.is_empty = zero_none | ~|b_inc;
      end
    endcase
  end

  assign in_full   = (cnt_r == QC_W'(QD));
  assign job_valid = (cnt_r != '0);
  assign job       = q_r[rd_ptr_r];
  assign push_ok   = in_push & ~in_full;
  assign take_ok   = job_take & job_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QD - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (take_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QD - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_ok && !take_ok) begin
      cnt_nxt = cnt_r + QC_W'(1);
    end else if (take_ok && !push_ok) begin
      cnt_nxt = cnt_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push_ok) begin
      q_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

[rtl/core/zor_back.sv]
// Back end of the zero/one range encoder: bit-serial prefix walk per job.
// Drives the result register. Depends on zor_pkg.
module zor_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  zor_pkg::job_t      job,
  output logic               job_take,
  output logic               out_empty,
  input  logic               out_pop,
  output zor_pkg::out_item_t out_data
);

  localparam int W     = zor_pkg::VALUE_BITS;
  localparam int POS_W = zor_pkg::POS_W;
  localparam int CNT_W = zor_pkg::CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NORM,
    S_WALK
  } state_t;

  state_t             state_r, state_nxt;
  zor_pkg::op_t       op_r, op_nxt;
  logic [W-1:0]       sa_r, sa_nxt;
  logic [W-1:0]       sb_r, sb_nxt;
  logic [W-1:0]       ma_r, ma_nxt;
  logic [W-1:0]       mb_r, mb_nxt;
  logic [W-1:0]       pre_r, pre_nxt;
  logic [POS_W-1:0]   zc_r, zc_nxt;
  logic [POS_W-1:0]   oc_r, oc_nxt;
  logic [CNT_W-1:0]   ec_r, ec_nxt;
  zor_pkg::out_item_t out_r, out_nxt;
  logic               out_v_r, out_v_nxt;

  zor_pkg::out_item_t res;
  logic               emit;
  logic               slot_free;
  logic               ta, tb;
  logic               rest_zero, rest_one;
  logic               cap;
  logic               hit;
  logic               last;
  logic [W-1:0]       elem;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    pre_nxt   = pre_r;
    zc_nxt    = zc_r;
    oc_nxt    = oc_r;
    ec_nxt    = ec_r;
    job_take  = 1'b0;
    emit      = 1'b0;
    res       = '0;
    hit       = 1'b0;
    last      = 1'b0;
    slot_free = !out_v_r || out_pop;
    ta        = sa_r[W-1];
    tb        = sb_r[W-1];
    rest_zero = |(~sa_r[W-2:0] & ma_r[W-2:0]);
    rest_one  = |sa_r[W-2:0];
    cap       = (ec_r == CNT_W'(zor_pkg::MAX_RESULTS - 1));
    elem      = {pre_r[W-2:0], 1'b1};

    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          if (job.is_empty) begin
            if (slot_free) begin
              job_take     = 1'b1;
              emit         = 1'b1;
              res.is_last  = 1'b1;
              res.is_empty = 1'b1;
            end
          end else begin
            job_take  = 1'b1;
            op_nxt    = job.op;
            sa_nxt    = job.val_a;
            sb_nxt    = (job.op == zor_pkg::OP_CMP) ? job.val_b : '1;
            ma_nxt    = '1;
            mb_nxt    = '1;
            pre_nxt   = '0;
            zc_nxt    = '0;
            oc_nxt    = '0;
            ec_nxt    = '0;
            state_nxt = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (!ta) begin
          sa_nxt = {sa_r[W-2:0], 1'b0};
          ma_nxt = {ma_r[W-2:0], 1'b0};
        end
        if (!tb) begin
          sb_nxt = {sb_r[W-2:0], 1'b0};
          mb_nxt = {mb_r[W-2:0], 1'b0};
        end
        if (ta && tb) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        case (op_r)
          zor_pkg::OP_ZERO, zor_pkg::OP_ONE: begin
            hit  = (op_r == zor_pkg::OP_ONE) ? ta : !ta;
            last = cap || ((op_r == zor_pkg::OP_ONE) ? !rest_one : !rest_zero);
            if (!hit || slot_free) begin
              sa_nxt  = {sa_r[W-2:0], 1'b0};
              ma_nxt  = {ma_r[W-2:0], 1'b0};
              pre_nxt = {pre_r[W-2:0], ta};
              if (hit) begin
                emit        = 1'b1;
                res.element = elem;
                res.is_last = last;
                ec_nxt      = ec_r + CNT_W'(1);
                if (last) begin
                  state_nxt = S_IDLE;
                end
              end
            end
          end
          default: begin
            if (!ma_r[W-1] || !mb_r[W-1]) begin
              if (slot_free) begin
                emit        = 1'b1;
                res.is_last = 1'b1;
                state_nxt   = S_IDLE;
              end
            end else if (!ta && tb) begin
              if (slot_free) begin
                emit              = 1'b1;
                res.element       = elem;
                res.is_last       = 1'b1;
                res.matched       = 1'b1;
                res.zero_position = zc_r + POS_W'(1);
                res.one_position  = oc_r + POS_W'(1);
                state_nxt         = S_IDLE;
              end
            end else if (ta != tb) begin
              if (slot_free) begin
                emit        = 1'b1;
                res.is_last = 1'b1;
                state_nxt   = S_IDLE;
              end
            end else begin
              sa_nxt  = {sa_r[W-2:0], 1'b0};
              sb_nxt  = {sb_r[W-2:0], 1'b0};
              ma_nxt  = {ma_r[W-2:0], 1'b0};
              mb_nxt  = {mb_r[W-2:0], 1'b0};
              pre_nxt = {pre_r[W-2:0], ta};
              zc_nxt  = zc_r + {{(POS_W - 1){1'b0}}, ~ta};
              oc_nxt  = oc_r + {{(POS_W - 1){1'b0}}, tb};
            end
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_nxt   = out_r;
    out_v_nxt = out_v_r;
    if (emit) begin
      out_nxt   = res;
      out_v_nxt = 1'b1;
    end else if (out_pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
    op_r  <= op_nxt;
    sa_r  <= sa_nxt;
    sb_r  <= sb_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    pre_r <= pre_nxt;
    zc_r  <= zc_nxt;
    oc_r  <= oc_nxt;
    ec_r  <= ec_nxt;
    out_r <= out_nxt;
  end

  assign out_empty = !out_v_r;
  assign out_data  = out_r;

endmodule

[rtl/core/zor_checker.sv]
// Port-level checker for the zero/one range encoder, bound to the top level.
// Depends on zor_pkg and zero_one_range_encoder_assert.svh.
`include "zero_one_range_encoder_assert.svh"

module zor_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input zor_pkg::in_item_t  in_data,
  input logic               out_empty,
  input logic               out_pop,
  input zor_pkg::out_item_t out_data
);

  `ZOR_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_data), "Stalled result beat changed")
  `ZOR_ASSERT_SAME(a_empty_beat, !out_empty && out_data.is_empty, out_data.is_last && out_data.element == '0 && !out_data.matched, "Empty set beat is malformed")
  `ZOR_ASSERT_SAME(a_match_beat, !out_empty && out_data.matched, out_data.is_last && !out_data.is_empty && out_data.zero_position != '0 && out_data.one_position != '0, "Match beat is malformed")
  `ZOR_ASSERT_SAME(a_no_match_pos, !out_empty && !out_data.matched, out_data.zero_position == '0 && out_data.one_position == '0, "Positions set without a match")

endmodule

bind zero_one_range_encoder zor_checker u_checker (.*);

[bench/zor_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the zero/one range encoder: predicts the result beats of every
// accepted input beat and compares them, in order, with the beats popped from the block.
// Depends on zor_pkg for the payload types and widths.
module zor_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  zor_pkg::in_item_t  in_data,
  input  logic               out_empty,
  input  logic               out_pop,
  input  zor_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 waiting_beats,
  output int                 checked_beats
);
  import zor_pkg::*;

  localparam int VB = VALUE_BITS;

  out_item_t        expected_results[$];
  logic [VB-1:0]    prefix_elems[2][MAX_RESULTS];
  int               prefix_count[2];

  function automatic void build_prefixes(input logic [VB-1:0] v, input bit ones);
    logic [VB-1:0] p;
    int            n;
    n = 0;
    for (int i = VB - 1; i >= 0; i--) begin
      p = v >> i;
      if (p != '0 && p[0] == ones && n < MAX_RESULTS) begin
        prefix_elems[ones][n] = p | VB'(1);
        n++;
      end
    end
    prefix_count[ones] = n;
  endfunction

  function automatic out_item_t make_result(input logic [VB-1:0] elem, input logic last,
                                            input logic empty, input logic match,
                                            input int zpos, input int opos);
    out_item_t r;
    r.element       = elem;
    r.is_last       = last;
    r.is_empty      = empty;
    r.matched       = match;
    r.zero_position = POS_W'(zpos);
    r.one_position  = POS_W'(opos);
    return r;
  endfunction

  task automatic encode_item(input in_item_t it);
    bit ones;
    int zi;
    int oi;
    bit found;
    if (it.mode == MODE_ZERO || it.mode == MODE_ONE) begin
      ones = (it.mode == MODE_ONE);
      build_prefixes(ones ? it.value_a + VB'(1) : it.value_a, ones);
      if (prefix_count[ones] == 0) begin
        expected_results.push_back(make_result('0, 1'b1, 1'b1, 1'b0, 0, 0));
      end else begin
        for (int k = 0; k < prefix_count[ones]; k++) begin
          expected_results.push_back(make_result(prefix_elems[ones][k],
                                                 k == prefix_count[ones] - 1,
                                                 1'b0, 1'b0, 0, 0));
        end
      end
    end else begin
      build_prefixes(it.value_a, 1'b0);
      build_prefixes(it.value_b + VB'(1), 1'b1);
      zi = 0;
      oi = 0;
      found = 1'b0;
      while (!found && zi < prefix_count[0] && oi < prefix_count[1]) begin
        if (prefix_elems[0][zi] == prefix_elems[1][oi]) begin
          found = 1'b1;
        end else if (prefix_elems[0][zi] < prefix_elems[1][oi]) begin
          zi++;
        end else begin
          oi++;
        end
      end
      if (found) begin
        expected_results.push_back(make_result(prefix_elems[0][zi], 1'b1, 1'b0, 1'b1,
                                               zi + 1, oi + 1));
      end else begin
        expected_results.push_back(make_result('0, 1'b1,
                                               prefix_count[0] == 0 || prefix_count[1] == 0,
                                               1'b0, 0, 0));
      end
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      fail_count    <= 0;
      waiting_beats <= 0;
      checked_beats <= 0;
    end else begin
      if (in_push && !in_full) begin
        encode_item(in_data);
      end
      if (!out_empty && out_pop) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) begin
            $display("Unexpected result beat: element=%0h last=%0b empty=%0b match=%0b",
                     out_data.element, out_data.is_last, out_data.is_empty,
                     out_data.matched);
          end
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            if (fail_count < 10) begin
              $display({"Mismatch on beat %0d: expected elem=%0h last=%0b empty=%0b",
                        " match=%0b zpos=%0d opos=%0d"},
                       checked_beats, want.element, want.is_last, want.is_empty,
                       want.matched, want.zero_position, want.one_position);
              $display("  got elem=%0h last=%0b empty=%0b match=%0b zpos=%0d opos=%0d",
                       out_data.element, out_data.is_last, out_data.is_empty,
                       out_data.matched, out_data.zero_position, out_data.one_position);
            end
            fail_count <= fail_count + 1;
          end
        end
        checked_beats <= checked_beats + 1;
      end
      waiting_beats <= expected_results.size();
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Top of the zero/one range encoder testbench: clock, reset, bursty stimulus, a stalling
// result receiver and the verdict. Depends on zor_pkg, zero_one_range_encoder and
// zor_result_checker.
module tb;
  import zor_pkg::*;

  localparam int            VB           = VALUE_BITS;
  localparam int            LIMIT_CYCLES = 800000;
  localparam int            RANDOM_ITEMS = 450;
  localparam logic [MODE_W-1:0] MODE_CMP    = MODE_W'(OP_CMP);
  localparam logic [MODE_W-1:0] MODE_UNUSED = MODE_W'(3);
  localparam logic [VB-1:0] ALL_ONES     = '1;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      in_push = 1'b0;
  logic      out_pop = 1'b0;
  in_item_t  in_data = '0;
  logic      in_full;
  logic      out_empty;
  out_item_t out_data;
  int        fail_count;
  int        waiting_beats;
  int        checked_beats;
  int        burst_left = 0;
  int        mode_count[4] = '{0, 0, 0, 0};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  zero_one_range_encoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  zor_result_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data       (in_data),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .waiting_beats (waiting_beats),
    .checked_beats (checked_beats)
  );

  function automatic in_item_t item_of(input logic [MODE_W-1:0] mode, input logic [VB-1:0] a,
                                       input logic [VB-1:0] b);
    in_item_t it;
    it.mode    = mode;
    it.value_a = a;
    it.value_b = b;
    return it;
  endfunction

  function automatic logic [VB-1:0] rand_value();
    int unsigned   len;
    logic [VB-1:0] v;
    len = $urandom_range(0, 15);
    v   = VB'($urandom);
    if (len == 0) begin
      v = ALL_ONES;
    end else if (len == 1) begin
      v = '0;
    end else begin
      len = $urandom_range(1, VB);
      if (len < VB) begin
        v = v & ((VB'(1) << len) - VB'(1));
      end
      v[len - 1] = 1'b1;
    end
    return v;
  endfunction

  task automatic offer(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    mode_count[it.mode]++;
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  initial begin : receiver
    int         style;
    int         style_left;
    int         hold_left;
    int         next_hold;
    logic [7:0] pattern;
    style      = 0;
    style_left = 0;
    hold_left  = 0;
    next_hold  = 150;
    pattern    = 8'hFF;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (rst_n && checked_beats >= next_hold) begin
        hold_left = 250;
        next_hold = next_hold + 1200;
        out_pop <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(20, 120);
          pattern    = 8'($urandom);
        end
        style_left--;
        case (style)
          0: begin
            out_pop <= 1'b1;
          end
          1: begin
            out_pop <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
          2: begin
            out_pop <= ($urandom_range(0, 2) != 0);
          end
          default: begin
            out_pop <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  initial begin : limit
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [VB-1:0] a;
    logic [VB-1:0] b;
    logic [MODE_W-1:0] mode;
    int unsigned   r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(item_of(MODE_ZERO, '0, ALL_ONES));
    offer(item_of(MODE_ZERO, ALL_ONES, '0));
    offer(item_of(MODE_ZERO, VB'(1), VB'(32'h2AAAAAAA)));
    offer(item_of(MODE_ZERO, VB'(1) << (VB - 1), VB'(32'h55555555)));
    offer(item_of(MODE_ZERO, VB'(32'h2AAAAAAA), ALL_ONES));
    offer(item_of(MODE_ZERO, VB'(32'h55555555), '0));
    offer(item_of(MODE_ONE, '0, '0));
    offer(item_of(MODE_ONE, ALL_ONES, ALL_ONES));
    offer(item_of(MODE_ONE, ALL_ONES - VB'(1), '0));
    offer(item_of(MODE_ONE, (VB'(1) << (VB - 1)) - VB'(1), '0));
    offer(item_of(MODE_ONE, VB'(32'h2AAAAAAA), '0));
    offer(item_of(MODE_CMP, VB'(5), VB'(5)));
    offer(item_of(MODE_CMP, VB'(6), VB'(5)));
    offer(item_of(MODE_CMP, '0, '0));
    offer(item_of(MODE_CMP, VB'(3), ALL_ONES));
    offer(item_of(MODE_CMP, ALL_ONES, VB'(7)));
    offer(item_of(MODE_CMP, '0, ALL_ONES - VB'(1)));
    offer(item_of(MODE_CMP, ALL_ONES - VB'(1), ALL_ONES - VB'(1)));
    offer(item_of(MODE_CMP, VB'(1), '0));
    offer(item_of(MODE_CMP, VB'(32'h2AAAAAAA), VB'(32'h55555555)));
    offer(item_of(MODE_UNUSED, VB'(10), VB'(20)));
    offer(item_of(MODE_UNUSED, VB'(20), VB'(10)));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        mode = MODE_ZERO;
      end else if (r < 60) begin
        mode = MODE_ONE;
      end else if (r < 95) begin
        mode = MODE_CMP;
      end else begin
        mode = MODE_UNUSED;
      end
      a = rand_value();
      case ($urandom_range(0, 4))
        0: b = VB'($urandom);
        1: b = a + VB'($urandom_range(0, 40));
        2: b = a - VB'($urandom_range(1, 40));
        3: b = a;
        default: b = rand_value();
      endcase
      offer(item_of(mode, a, b));
    end
    in_push <= 1'b0;
    @(posedge clk);
    wait (waiting_beats == 0);
    repeat (40) @(posedge clk);

    $display("Ran %0d zero-encode, %0d one-encode and %0d compare items (%0d as unused mode).",
             mode_count[MODE_ZERO], mode_count[MODE_ONE],
             mode_count[MODE_CMP] + mode_count[MODE_UNUSED], mode_count[MODE_UNUSED]);
    $display("Checked %0d result beats with %0d failures.", checked_beats, fail_count);
    if (fail_count == 0 && waiting_beats == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/zor_pkg.sv
rtl/core/zor_front.sv
rtl/core/zor_back.sv
rtl/core/zero_one_range_encoder.sv
rtl/core/zor_checker.sv
bench/zor_result_checker.sv
bench/tb.sv
